[rtl/lruc_pkg.sv]
// Shared codes and control types for the LRU cache with expiry.
`default_nettype none
package lruc_pkg;

  localparam int CAP_BITS  = 5;
  localparam int LIFE_BITS = 31;

  localparam logic [1:0] ACT_PUT  = 2'd0;
  localparam logic [1:0] ACT_GET  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;
  localparam logic [1:0] ST_TICK   = 2'd3;

  typedef struct packed {
    logic update;
    logic hit_any;
    logic evict;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/lruc_cell.sv]
// One recency position of the cache: holds an entry and shifts it from its neighbor.
`default_nettype none
module lruc_cell #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64,
  parameter int TIME_BITS  = 32
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire  lruc_pkg::cell_ctrl_t ctrl,
  input  wire  [KEY_BITS-1:0]       req_key,
  input  wire                       prev_valid,
  input  wire  [KEY_BITS-1:0]       prev_key,
  input  wire  [VALUE_BITS-1:0]     prev_value,
  input  wire  [TIME_BITS-1:0]      prev_expiry,
  input  wire                       below_hit,
  output logic                      valid,
  output logic [KEY_BITS-1:0]       key,
  output logic [VALUE_BITS-1:0]     value,
  output logic [TIME_BITS-1:0]      expiry,
  output logic                      match,
  output logic                      hit_chain
);
  import lruc_pkg::*;

  logic shift;

  assign match     = valid && (key == req_key);
  assign hit_chain = match || below_hit;

  // take from the more recent neighbor when at or above the target position
  always_comb begin
    if (ctrl.hit_any) begin
      shift = hit_chain;
    end else if (ctrl.evict) begin
      shift = valid;
    end else begin
      shift = prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.update && shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update && shift) begin
      key    <= prev_key;
      value  <= prev_value;
      expiry <= prev_expiry;
    end
  end

endmodule
`default_nettype wire

[rtl/lru_cache_with_ttl_core.sv]
// Top level of the fully associative LRU cache with per-entry expiry.
//
//   channel   signals                                           direction
//   request   req_valid req_ready action lookup_key
//             store_value lifetime                               in
//   response  resp_valid resp_ready status read_value evicted    out
//   config    cfg_write cfg_wdata (capacity)                     in
//
// Each request is first registered; in the compare cycle (S_LOOK) the key compare
// across the cell row, the recency shift and the response register load happen.
// The cells are ordered by recency; an unexpired get hit or a put shifts the row by one.
// Reset clears all valid bits, the time counter and sets capacity to ENTRIES.
// A waiting response holds the compare cycle until it is taken.
`default_nettype none
module lru_cache_with_ttl_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64,
  parameter int TIME_BITS  = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               req_valid,
  output logic                              req_ready,
  input  wire  [1:0]                        action,
  input  wire  [63:0]                       lookup_key,
  input  wire  [63:0]                       store_value,
  input  wire  [lruc_pkg::LIFE_BITS-1:0]    lifetime,
  output logic                              resp_valid,
  input  wire                               resp_ready,
  output logic [1:0]                        status,
  output logic [63:0]                       read_value,
  output logic                              evicted,
  input  wire                               cfg_write,
  input  wire  [lruc_pkg::CAP_BITS-1:0]     cfg_wdata
);
  import lruc_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW    = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam int SUM_W = (TIME_BITS > LIFE_BITS) ? TIME_BITS : LIFE_BITS;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic                  state;
  logic [1:0]            act;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic [LIFE_BITS-1:0]  rlife;
  logic [TIME_BITS-1:0]  now;
  logic [CNT_W-1:0]      cnt;
  logic [CW-1:0]         capacity;

  logic                  cell_valid  [ENTRIES];
  logic [KEY_BITS-1:0]   cell_key    [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value  [ENTRIES];
  logic [TIME_BITS-1:0]  cell_expiry [ENTRIES];
  logic                  cell_match  [ENTRIES];
  logic                  cell_chain  [ENTRIES];

  cell_ctrl_t            ctrl;
  logic                  fire;
  logic                  is_put;
  logic                  is_get;
  logic                  hit_any;
  logic                  expired;
  logic                  evict;
  logic [CW-1:0]         cap_eff;
  logic [VALUE_BITS-1:0] sel_value;
  logic [TIME_BITS-1:0]  sel_expiry;
  logic [TIME_BITS-1:0]  diff;
  logic [SUM_W-1:0]      exp_sum;
  logic [VALUE_BITS-1:0] head_value;
  logic [TIME_BITS-1:0]  head_expiry;
  logic [1:0]            status_next;
  logic [63:0]           read_value_next;

  assign req_ready = (state == S_IDLE);
  assign fire      = (state == S_LOOK) && (!resp_valid || resp_ready);
  assign is_put    = (act == ACT_PUT);
  assign is_get    = (act == ACT_GET);
  assign hit_any   = cell_chain[0];

  always_comb begin
    sel_value  = '0;
    sel_expiry = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        sel_value  = sel_value | cell_value[i];
        sel_expiry = sel_expiry | cell_expiry[i];
      end
    end
  end

  assign diff    = sel_expiry - now;
  assign expired = (diff == '0) || diff[TIME_BITS-1];
  assign exp_sum = SUM_W'(now) + SUM_W'(rlife);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (capacity > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = capacity;
    end
  end

  assign evict = is_put && !hit_any && (CW'(cnt) >= cap_eff);

  assign head_value  = is_put ? rval : sel_value;
  assign head_expiry = is_put ? exp_sum[TIME_BITS-1:0] : sel_expiry;

  always_comb begin
    ctrl.update  = fire && (is_put || (is_get && hit_any && !expired));
    ctrl.hit_any = hit_any;
    ctrl.evict   = evict;
  end

  always_comb begin
    read_value_next = '0;
    unique case (act)
      ACT_PUT: status_next = ST_STORED;
      ACT_GET: begin
        if (hit_any && !expired) begin
          status_next     = ST_HIT;
          read_value_next = 64'(sel_value);
        end else begin
          status_next = ST_MISS;
        end
      end
      ACT_TICK: status_next = ST_TICK;
      default:  status_next = ST_MISS;
    endcase
  end

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    logic                  pv;
    logic [KEY_BITS-1:0]   pk;
    logic [VALUE_BITS-1:0] pval;
    logic [TIME_BITS-1:0]  pe;
    logic                  below;

    if (j == 0) begin : g_head
      assign pv   = 1'b1;
      assign pk   = rkey;
      assign pval = head_value;
      assign pe   = head_expiry;
    end else begin : g_link
      assign pv   = cell_valid[j-1];
      assign pk   = cell_key[j-1];
      assign pval = cell_value[j-1];
      assign pe   = cell_expiry[j-1];
    end

    if (j == ENTRIES - 1) begin : g_tail
      assign below = 1'b0;
    end else begin : g_mid
      assign below = cell_chain[j+1];
    end

    lruc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .TIME_BITS  (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .req_key     (rkey),
      .prev_valid  (pv),
      .prev_key    (pk),
      .prev_value  (pval),
      .prev_expiry (pe),
      .below_hit   (below),
      .valid       (cell_valid[j]),
      .key         (cell_key[j]),
      .value       (cell_value[j]),
      .expiry      (cell_expiry[j]),
      .match       (cell_match[j]),
      .hit_chain   (cell_chain[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      resp_valid <= 1'b0;
      now        <= '0;
      cnt        <= '0;
      capacity   <= CW'(ENTRIES);
    end else begin
      if (cfg_write) begin
        capacity <= CW'(cfg_wdata);
      end
      if (state == S_IDLE) begin
        if (req_valid) begin
          state <= S_LOOK;
        end
        if (resp_ready) begin
          resp_valid <= 1'b0;
        end
      end else if (fire) begin
        state      <= S_IDLE;
        resp_valid <= 1'b1;
        if (act == ACT_TICK) begin
          now <= now + TIME_BITS'(1);
        end
        if (is_put && !hit_any && !evict) begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      act   <= action;
      rkey  <= lookup_key[KEY_BITS-1:0];
      rval  <= store_value[VALUE_BITS-1:0];
      rlife <= lifetime;
    end
    if (fire) begin
      status     <= status_next;
      read_value <= read_value_next;
      evicted    <= evict;
    end
  end

endmodule
`default_nettype wire
